>>> hw/rtl/tdsc_pkg.sv
`default_nettype none

package tdsc_pkg;

  // Register indexes on the configuration channel.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHALLOW_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEEP_LIMIT   = 2'd2;

  // Register widths, data width of the configuration channel and reset values.
  localparam int CFG_DATA_W = 10;
  localparam int DZ_W       = 7;
  localparam int LIM_W      = 10;
  localparam logic [DZ_W-1:0]  DZ_RESET      = 7'd2;
  localparam logic [LIM_W-1:0] SHALLOW_RESET = 10'd55;
  localparam logic [LIM_W-1:0] STEEP_RESET   = 10'd170;

  // Slope scale factor and the number of bits it adds to a product.
  localparam int SLOPE_SCALE   = 100;
  localparam int SLOPE_SCALE_W = 7;

  // Board LED numbers.
  localparam int LED_W = 4;
  localparam logic [LED_W-1:0] LED_NONE      = 4'd0;
  localparam logic [LED_W-1:0] LED_STEEP_L   = 4'd4;
  localparam logic [LED_W-1:0] LED_MID_L     = 4'd5;
  localparam logic [LED_W-1:0] LED_SHALLOW_L = 4'd6;
  localparam logic [LED_W-1:0] LED_NSHAL_L   = 4'd7;
  localparam logic [LED_W-1:0] LED_NMID_L    = 4'd8;
  localparam logic [LED_W-1:0] LED_NSTEEP_L  = 4'd9;
  localparam logic [LED_W-1:0] LED_STEEP_R   = 4'd10;
  localparam logic [LED_W-1:0] LED_MID_R     = 4'd11;
  localparam logic [LED_W-1:0] LED_SHALLOW_R = 4'd12;
  localparam logic [LED_W-1:0] LED_NSHAL_R   = 4'd13;
  localparam logic [LED_W-1:0] LED_NMID_R    = 4'd14;
  localparam logic [LED_W-1:0] LED_NSTEEP_R  = 4'd15;

endpackage

`default_nettype wire

>>> hw/rtl/tdsc_ifs.sv
`default_nettype none

// Sample channel into the classifier.
interface tdsc_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [SAMPLE_BITS-1:0] x_sample;
  logic signed [SAMPLE_BITS-1:0] y_sample;

  modport source (output valid, output cmd, output x_sample, output y_sample, input ready);
  modport sink   (input valid, input cmd, input x_sample, input y_sample, output ready);
endinterface

// Result channel out of the classifier.
interface tdsc_out_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                          valid;
  logic                          ready;
  logic                          led_valid;
  logic [tdsc_pkg::LED_W-1:0]    led_number;
  logic signed [SAMPLE_BITS:0]   x_delta;
  logic signed [SAMPLE_BITS:0]   y_delta;

  modport source (output valid, output led_valid, output led_number,
                  output x_delta, output y_delta, input ready);
  modport sink   (input valid, input led_valid, input led_number,
                  input x_delta, input y_delta, output ready);
endinterface

// Register write channel.
interface tdsc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tdsc_pkg::CFG_IDX_W-1:0]    index;
  logic [tdsc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tdsc_divider.sv
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module tdsc_divider #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] diff;
  logic           ge;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  // Next-state logic: load on start, then shift quotient bits into the dividend.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

`default_nettype wire

>>> hw/rtl/tdsc_sector.sv
`default_nettype none

// Maps a signed slope and the sign of dx onto one of the twelve LEDs.
module tdsc_sector #(
  parameter int SLOPE_W = 18
) (
  input  wire logic signed [SLOPE_W-1:0]       slope,
  input  wire logic                            dx_neg,
  input  wire logic [tdsc_pkg::LIM_W-1:0]      shallow_limit,
  input  wire logic [tdsc_pkg::LIM_W-1:0]      steep_limit,
  output logic [tdsc_pkg::LED_W-1:0]           led_number
);

  logic signed [SLOPE_W-1:0] s_lim;
  logic signed [SLOPE_W-1:0] t_lim;
  logic signed [SLOPE_W-1:0] s_neg;
  logic signed [SLOPE_W-1:0] t_neg;

  // Limits are unsigned; zero-extend them into the slope width.
  assign s_lim = $signed(SLOPE_W'(shallow_limit));
  assign t_lim = $signed(SLOPE_W'(steep_limit));
  assign s_neg = -s_lim;
  assign t_neg = -t_lim;

  // The sector tests are applied in priority order; the first match decides.
  always_comb begin
    if (slope > 0 && slope < s_lim) begin
      led_number = dx_neg ? tdsc_pkg::LED_SHALLOW_L : tdsc_pkg::LED_SHALLOW_R;
    end else if (slope >= s_lim && slope < t_lim) begin
      led_number = dx_neg ? tdsc_pkg::LED_MID_L : tdsc_pkg::LED_MID_R;
    end else if (slope >= t_lim) begin
      led_number = dx_neg ? tdsc_pkg::LED_STEEP_L : tdsc_pkg::LED_STEEP_R;
    end else if (slope <= 0 && slope > s_neg) begin
      led_number = dx_neg ? tdsc_pkg::LED_NSHAL_L : tdsc_pkg::LED_NSHAL_R;
    end else if (slope <= s_neg && slope > t_neg) begin
      led_number = dx_neg ? tdsc_pkg::LED_NMID_L : tdsc_pkg::LED_NMID_R;
    end else begin
      led_number = dx_neg ? tdsc_pkg::LED_NSTEEP_L : tdsc_pkg::LED_NSTEEP_R;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tilt_direction_sector_classifier_top.sv
// Measurement: after a transfer S_MEAS starts the one-bit-per-cycle divider, S_WAITS
// waits for it and S_OUT loads the result; a dead-zone item skips the divider.
// Calibration: samples are taken while idle; the sample that completes a group adds two
// divisions, x offset then y offset, before the next sample is taken.
// One item is in work at a time; a finished result waits in the output register.
// Synchronous active-low reset: offsets, sums and count go to zero, registers to defaults.
`default_nettype none

module tilt_direction_sector_classifier_top #(
  parameter int CAL_SAMPLES = 8,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tdsc_in_if.sink    in_ch,
  tdsc_out_if.source out_ch,
  tdsc_cfg_if.sink   cfg_ch
);

  localparam int ADJ_W   = SAMPLE_BITS + 1;
  localparam int SUM_W   = SAMPLE_BITS + $clog2(CAL_SAMPLES);
  localparam int CNT_W   = $clog2(CAL_SAMPLES);
  localparam int DEN_W   = SAMPLE_BITS;
  localparam int NUM_W   = SAMPLE_BITS + tdsc_pkg::SLOPE_SCALE_W;
  localparam int SLOPE_W = NUM_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFX,
    S_WAITX,
    S_OFFY,
    S_WAITY,
    S_MEAS,
    S_WAITS,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [tdsc_pkg::DZ_W-1:0]  dz_r, dz_nxt;
  logic [tdsc_pkg::LIM_W-1:0] shallow_r, shallow_nxt;
  logic [tdsc_pkg::LIM_W-1:0] steep_r, steep_nxt;

  logic signed [SAMPLE_BITS-1:0] xoff_r, xoff_nxt;
  logic signed [SAMPLE_BITS-1:0] yoff_r, yoff_nxt;
  logic signed [SUM_W-1:0]       xsum_r, xsum_nxt;
  logic signed [SUM_W-1:0]       ysum_r, ysum_nxt;
  logic [CNT_W-1:0]              cal_cnt_r, cal_cnt_nxt;

  logic signed [ADJ_W-1:0] ax_r, ax_nxt;
  logic signed [ADJ_W-1:0] ay_r, ay_nxt;
  logic                    div_neg_r, div_neg_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [tdsc_pkg::LED_W-1:0] pend_led_r, pend_led_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_led_valid_r, out_led_valid_nxt;
  logic [tdsc_pkg::LED_W-1:0] out_led_r, out_led_nxt;
  logic signed [ADJ_W-1:0]    out_ax_r, out_ax_nxt;
  logic signed [ADJ_W-1:0]    out_ay_r, out_ay_nxt;

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_q;

  logic                      in_xfer;
  logic                      cfg_xfer;
  logic signed [ADJ_W-1:0]   ax_abs;
  logic signed [ADJ_W-1:0]   ay_abs;
  logic [SAMPLE_BITS-1:0]    mx;
  logic [SAMPLE_BITS-1:0]    my;
  logic                      dead;
  logic signed [SUM_W:0]     xsum_ext;
  logic signed [SUM_W:0]     ysum_ext;
  logic signed [SUM_W:0]     xsum_abs;
  logic signed [SUM_W:0]     ysum_abs;
  logic [NUM_W-1:0]          q_signed;
  logic signed [SLOPE_W-1:0] slope;
  logic [tdsc_pkg::LED_W-1:0] sector_led;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;

  // Magnitudes for the dead-zone test and the slope division; zero dx counts as 1.
  assign ax_abs = ax_r[ADJ_W-1] ? -ax_r : ax_r;
  assign ay_abs = ay_r[ADJ_W-1] ? -ay_r : ay_r;
  assign mx     = (ax_r == '0) ? SAMPLE_BITS'(1) : ax_abs[SAMPLE_BITS-1:0];
  assign my     = ay_abs[SAMPLE_BITS-1:0];
  assign dead   = (mx < SAMPLE_BITS'(dz_r)) && (my < SAMPLE_BITS'(dz_r));

  // Sum magnitudes, widened by one bit so the most negative sum negates cleanly.
  assign xsum_ext = (SUM_W + 1)'(xsum_r);
  assign ysum_ext = (SUM_W + 1)'(ysum_r);
  assign xsum_abs = xsum_r[SUM_W-1] ? -xsum_ext : xsum_ext;
  assign ysum_abs = ysum_r[SUM_W-1] ? -ysum_ext : ysum_ext;

  // Quotient with its sign restored: truncation toward zero.
  assign q_signed = div_neg_r ? -div_q : div_q;
  assign slope    = div_neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  tdsc_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  tdsc_sector #(
    .SLOPE_W (SLOPE_W)
  ) u_sector (
    .slope         (slope),
    .dx_neg        (ax_r[ADJ_W-1]),
    .shallow_limit (shallow_r),
    .steep_limit   (steep_r),
    .led_number    (sector_led)
  );

  // Sequencer: accumulate, divide for offsets, or classify one measurement.
  always_comb begin
    state_nxt         = state_r;
    dz_nxt            = dz_r;
    shallow_nxt       = shallow_r;
    steep_nxt         = steep_r;
    xoff_nxt          = xoff_r;
    yoff_nxt          = yoff_r;
    xsum_nxt          = xsum_r;
    ysum_nxt          = ysum_r;
    cal_cnt_nxt       = cal_cnt_r;
    ax_nxt            = ax_r;
    ay_nxt            = ay_r;
    div_neg_nxt       = div_neg_r;
    pend_valid_nxt    = pend_valid_r;
    pend_led_nxt      = pend_led_r;
    out_valid_nxt     = out_valid_r;
    out_led_valid_nxt = out_led_valid_r;
    out_led_nxt       = out_led_r;
    out_ax_nxt        = out_ax_r;
    out_ay_nxt        = out_ay_r;
    div_start         = 1'b0;
    div_num           = NUM_W'(xsum_abs);
    div_den           = DEN_W'(CAL_SAMPLES);

    // Register writes.
    if (cfg_xfer) begin
      unique case (cfg_ch.index)
        tdsc_pkg::CFG_DEAD_ZONE:     dz_nxt      = cfg_ch.data[tdsc_pkg::DZ_W-1:0];
        tdsc_pkg::CFG_SHALLOW_LIMIT: shallow_nxt = cfg_ch.data[tdsc_pkg::LIM_W-1:0];
        tdsc_pkg::CFG_STEEP_LIMIT:   steep_nxt   = cfg_ch.data[tdsc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end

    // The output register empties on a transfer.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.cmd) begin
            ax_nxt    = ADJ_W'($signed(in_ch.x_sample)) - ADJ_W'(xoff_r);
            ay_nxt    = ADJ_W'($signed(in_ch.y_sample)) - ADJ_W'(yoff_r);
            state_nxt = S_MEAS;
          end else begin
            xsum_nxt = xsum_r + SUM_W'($signed(in_ch.x_sample));
            ysum_nxt = ysum_r + SUM_W'($signed(in_ch.y_sample));
            if (cal_cnt_r == CNT_W'(CAL_SAMPLES - 1)) begin
              cal_cnt_nxt = '0;
              state_nxt   = S_OFFX;
            end else begin
              cal_cnt_nxt = cal_cnt_r + CNT_W'(1);
            end
          end
        end
      end
      S_OFFX: begin
        div_start   = 1'b1;
        div_num     = NUM_W'(xsum_abs);
        div_neg_nxt = xsum_r[SUM_W-1];
        state_nxt   = S_WAITX;
      end
      S_WAITX: begin
        if (div_done) begin
          xoff_nxt  = $signed(q_signed[SAMPLE_BITS-1:0]);
          state_nxt = S_OFFY;
        end
      end
      S_OFFY: begin
        div_start   = 1'b1;
        div_num     = NUM_W'(ysum_abs);
        div_neg_nxt = ysum_r[SUM_W-1];
        state_nxt   = S_WAITY;
      end
      S_WAITY: begin
        if (div_done) begin
          yoff_nxt  = $signed(q_signed[SAMPLE_BITS-1:0]);
          xsum_nxt  = '0;
          ysum_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_MEAS: begin
        if (dead) begin
          pend_valid_nxt = 1'b0;
          pend_led_nxt   = tdsc_pkg::LED_NONE;
          state_nxt      = S_OUT;
        end else begin
          div_start   = 1'b1;
          div_num     = NUM_W'(my) * NUM_W'(tdsc_pkg::SLOPE_SCALE);
          div_den     = mx;
          div_neg_nxt = ax_r[ADJ_W-1] ^ ay_r[ADJ_W-1];
          state_nxt   = S_WAITS;
        end
      end
      S_WAITS: begin
        if (div_done) begin
          pend_valid_nxt = 1'b1;
          pend_led_nxt   = sector_led;
          state_nxt      = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt     = 1'b1;
          out_led_valid_nxt = pend_valid_r;
          out_led_nxt       = pend_led_r;
          out_ax_nxt        = ax_r;
          out_ay_nxt        = ay_r;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dz_r        <= tdsc_pkg::DZ_RESET;
      shallow_r   <= tdsc_pkg::SHALLOW_RESET;
      steep_r     <= tdsc_pkg::STEEP_RESET;
      xoff_r      <= '0;
      yoff_r      <= '0;
      xsum_r      <= '0;
      ysum_r      <= '0;
      cal_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dz_r        <= dz_nxt;
      shallow_r   <= shallow_nxt;
      steep_r     <= steep_nxt;
      xoff_r      <= xoff_nxt;
      yoff_r      <= yoff_nxt;
      xsum_r      <= xsum_nxt;
      ysum_r      <= ysum_nxt;
      cal_cnt_r   <= cal_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ax_r            <= ax_nxt;
    ay_r            <= ay_nxt;
    div_neg_r       <= div_neg_nxt;
    pend_valid_r    <= pend_valid_nxt;
    pend_led_r      <= pend_led_nxt;
    out_led_valid_r <= out_led_valid_nxt;
    out_led_r       <= out_led_nxt;
    out_ax_r        <= out_ax_nxt;
    out_ay_r        <= out_ay_nxt;
  end

  // Port drive.
  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.led_valid  = out_led_valid_r;
  assign out_ch.led_number = out_led_r;
  assign out_ch.x_delta    = out_ax_r;
  assign out_ch.y_delta    = out_ay_r;

  // A lit result always names a board LED.
  a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_led_valid_r |-> out_led_r >= tdsc_pkg::LED_STEEP_L)
    else $error("lit result with LED number below range");

  // A dead-zone result carries LED number zero.
  a_dead_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_led_valid_r |-> out_led_r == tdsc_pkg::LED_NONE)
    else $error("dead-zone result with nonzero LED number");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_WAITX || state_r == S_WAITY || state_r == S_WAITS))
    else $error("divider finished outside a wait state");

  // A measurement transfer blocks the input for the following cycle.
  a_meas_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_ch.cmd |=> !in_ch.ready)
    else $error("input ready right after a measurement transfer");

  // The calibration count wraps before reaching the group size.
  a_cal_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cal_cnt_r <= CNT_W'(CAL_SAMPLES - 1))
    else $error("calibration count out of range");

endmodule

`default_nettype wire
